[rtl/b64d_pkg.sv]
`default_nettype none
package b64d_pkg;

  // pad character and sextet code for a character outside the alphabet
  localparam logic [7:0] PadChar  = 8'h3D;
  localparam logic [6:0] NoSextet = 7'd64;

  // depth of the group queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // one decoded group: up to three bytes that one character released
  typedef struct packed {
    logic [2:0][7:0] bytes;   // bytes[0] goes out first
    logic [1:0]      nbytes;  // 1 to 3
    logic            bad;
    logic            fin;
  } group_t;

  // map an ascii code to its sextet, NoSextet when not in the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = NoSextet;
    if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
    else if (c == 8'h2B) v = 7'd62;
    else if (c == 8'h2F) v = 7'd63;
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/base64_stream_decoder.sv]
// base64 text decoder, standard alphabet
// slave channel: one ascii character per item on s_axis_tdata, tlast on the
// final character of a string. master channel: one decoded byte per item on
// m_axis_tdata, tuser set when the string was invalid (byte is then zero and
// earlier bytes of that string are void), tlast on the last byte of a string.
// a full quad gives three bytes; a final quad with one or two pads gives two
// or one. a bad string gives exactly one item with tuser and tlast set.
// the front takes one character every cycle while the four-entry group queue
// has room; the back drains one byte per cycle while the receiver is ready.
// the first byte of a group passes through the queue and then the output
// register after the character that completes it is accepted.
// reset clears the quad state, queue and output register; no clearing pass.
// when the receiver stalls the output item holds, the queue fills and then
// s_axis_tready drops until a group's last byte is in the output register.
`default_nettype none
module base64_stream_decoder (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // [7:0] char_in
  input  wire        s_axis_tlast,   // end_of_text
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] byte_out
  output logic       m_axis_tuser,   // [0] bad_input
  output logic       m_axis_tlast    // final_res
);

  logic             acc;
  logic             push, pop, empty, full;
  b64d_pkg::group_t wgroup, head;

  assign s_axis_tready = !full;
  assign acc           = s_axis_tvalid && s_axis_tready;

  b64d_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .char_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .push_o  (push),
    .group_o (wgroup)
  );

  b64d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wgroup),
    .pop_i   (pop),
    .rdata_o (head),
    .empty_o (empty),
    .full_o  (full)
  );

  b64d_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .byte_o  (m_axis_tdata),
    .bad_o   (m_axis_tuser),
    .fin_o   (m_axis_tlast)
  );

endmodule
`default_nettype wire

[rtl/b64d_front.sv]
`default_nettype none
module b64d_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  acc_i,       // character item accepted
  input  wire  [7:0]           char_i,
  input  wire                  last_i,
  output logic                 push_o,
  output b64d_pkg::group_t     group_o
);

  logic [1:0]  pos_q, pos_d;
  logic [17:0] buf_q, buf_d;
  logic        tp_q, tp_d;
  logic        err_q, err_d;

  logic [6:0]  v;
  logic        is_pad;
  logic        bad_v;
  logic        err;
  logic [1:0]  count;
  logic [5:0]  s3;
  logic [17:0] buf_n;
  logic        tp_n;

  assign v      = b64d_pkg::sextet_of(char_i);
  assign is_pad = (char_i == b64d_pkg::PadChar);
  assign bad_v  = (v == b64d_pkg::NoSextet);

  // classify the character against its slot in the quad
  always_comb begin
    err   = err_q;
    buf_n = buf_q;
    tp_n  = tp_q;
    count = 2'd0;
    s3    = 6'd0;
    if (!err_q) begin
      unique case (pos_q)
        2'd0, 2'd1: begin
          if (bad_v) err = 1'b1;
          else buf_n = {buf_q[11:0], v[5:0]};
        end
        2'd2: begin
          if (is_pad) begin
            tp_n  = 1'b1;
            buf_n = {buf_q[11:0], 6'd0};
          end else if (bad_v) err = 1'b1;
          else buf_n = {buf_q[11:0], v[5:0]};
        end
        default: begin
          if (tp_q) begin
            if (!is_pad || !last_i) err = 1'b1;
            else count = 2'd1;
          end else if (is_pad) begin
            if (!last_i) err = 1'b1;
            else count = 2'd2;
          end else if (bad_v) err = 1'b1;
          else begin
            s3    = v[5:0];
            count = 2'd3;
          end
        end
      endcase
    end
    if (last_i && pos_q != 2'd3) err = 1'b1;
    if (err) count = 2'd0;
  end

  // group for the queue
  always_comb begin
    group_o.bytes[0] = buf_n[17:10];
    group_o.bytes[1] = buf_n[9:2];
    group_o.bytes[2] = {buf_n[1:0], s3};
    group_o.nbytes   = count;
    group_o.bad      = 1'b0;
    group_o.fin      = last_i;
    if (last_i && err) begin
      group_o.bytes  = '0;
      group_o.nbytes = 2'd1;
      group_o.bad    = 1'b1;
    end
  end

  assign push_o = acc_i && (last_i || count != 2'd0);

  // next quad state
  always_comb begin
    pos_d = pos_q;
    buf_d = buf_q;
    tp_d  = tp_q;
    err_d = err_q;
    if (acc_i) begin
      if (last_i) begin
        pos_d = 2'd0;
        buf_d = '0;
        tp_d  = 1'b0;
        err_d = 1'b0;
      end else begin
        pos_d = pos_q + 2'd1;
        err_d = err;
        buf_d = (pos_q == 2'd3) ? 18'd0 : buf_n;
        tp_d  = (pos_q == 2'd3) ? 1'b0 : tp_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      buf_q <= '0;
      tp_q  <= 1'b0;
      err_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      buf_q <= buf_d;
      tp_q  <= tp_d;
      err_q <= err_d;
    end
  end

endmodule
`default_nettype wire

[rtl/b64d_fifo.sv]
`default_nettype none
module b64d_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire b64d_pkg::group_t wdata_i,
  input  wire                  pop_i,
  output b64d_pkg::group_t     rdata_o,
  output logic                 empty_o,
  output logic                 full_o
);

  b64d_pkg::group_t            mem_q [b64d_pkg::QDepth];
  logic [b64d_pkg::QAw-1:0]    wptr_q, rptr_q;
  logic [b64d_pkg::QAw:0]      cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (b64d_pkg::QAw+1)'(b64d_pkg::QDepth));
  assign rdata_o = mem_q[rptr_q];

  // group storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

[rtl/b64d_back.sv]
`default_nettype none
module b64d_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire b64d_pkg::group_t head_i,
  input  wire                  empty_i,
  output logic                 pop_o,
  output logic                 valid_o,
  input  wire                  ready_i,
  output logic [7:0]           byte_o,
  output logic                 bad_o,
  output logic                 fin_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       bad_q, fin_q;
  logic       load;
  logic       last_of_group;

  // output register free and a group waiting
  assign load          = !empty_i && (!valid_q || ready_i);
  assign last_of_group = (idx_q == head_i.nbytes - 2'd1);
  assign pop_o         = load && last_of_group;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (valid_q && ready_i) valid_d = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = last_of_group ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.bytes[idx_q];
      bad_q  <= head_i.bad;
      fin_q  <= head_i.fin && last_of_group;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign bad_o   = bad_q;
  assign fin_o   = fin_q;

endmodule
`default_nettype wire
